// ===== src/rtp_interleaved_header_rewriter_assert.svh =====
// ----------------------------------------------------------------------------
// RTP header rewriter assertion macros
// Same-cycle implication and next-cycle checks shared by the window core and the result buffer.
// ----------------------------------------------------------------------------
`ifndef RTP_INTERLEAVED_HEADER_REWRITER_ASSERT_SVH
`define RTP_INTERLEAVED_HEADER_REWRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTP_IHR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rtp_ihr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RTP_IHR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rtp_ihr: next-cycle check failed");

`endif

// ===== src/rtp_ihr_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP header rewriter package
// Shared constants, types and helpers for the interleaved RTP header rewriter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_ihr_pkg;

    // Window holds one interleaved prefix (4 bytes) plus a 12-byte RTP header.
    localparam int WinLen   = 16;
    localparam int FillW    = $clog2(WinLen);
    localparam int CountW   = $clog2(WinLen + 1);

    localparam logic [FillW-1:0] FullFill  = FillW'(WinLen - 1);
    localparam logic [FillW-1:0] StartFill = FillW'(5);

    // Header bytes
    localparam logic [7:0] HdrDollar  = 8'h24;
    localparam logic [7:0] HdrChan0   = 8'h00;
    localparam logic [7:0] HdrVersion = 8'h80;
    localparam logic [7:0] HdrPtLow   = 8'h60;
    localparam logic [7:0] HdrPtHigh  = 8'hE0;

    localparam logic [15:0] JumpThreshReset = 16'd100;

    // Item codes
    localparam logic OpData = 1'b0;
    localparam logic OpArm  = 1'b1;

    typedef logic [WinLen-1:0][7:0] byte_win_t;

    // Request from the window core to the result buffer
    typedef struct packed {
        logic              load;
        logic [CountW-1:0] count;
        logic              seg_flush;
    } drain_load_t;

    function automatic logic pt_ok(input logic [7:0] v);
        pt_ok = (v == HdrPtLow) || (v == HdrPtHigh);
    endfunction

endpackage

`default_nettype wire

// ===== src/rtp_ihr_window.sv =====
// ----------------------------------------------------------------------------
// RTP header rewriter window core
// Holds the 16-byte window, detects and rewrites RTP headers, hands results on.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtp_interleaved_header_rewriter_assert.svh"

module rtp_ihr_window
    import rtp_ihr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] jump_threshold,
    input  wire logic        item_valid,
    input  wire logic        item_opcode,
    input  wire logic [7:0]  item_byte,
    input  wire logic        item_seg_end,
    input  wire logic        drain_free,
    output logic             item_take,
    output drain_load_t      load,
    output byte_win_t        load_bytes
);

    byte_win_t          win_reg, win_next;
    logic [FillW-1:0]   fill_reg, fill_next;
    logic               head_reg, head_next;
    logic               started_reg, started_next;
    logic               armed_reg, armed_next;
    logic [15:0]        seq_off_reg, seq_off_next;
    logic [31:0]        time_off_reg, time_off_next;
    logic [31:0]        ssrc_ovr_reg, ssrc_ovr_next;
    logic [15:0]        last_in_seq_reg, last_in_seq_next;
    logic [31:0]        last_in_ssrc_reg, last_in_ssrc_next;
    logic [15:0]        last_out_seq_reg, last_out_seq_next;
    logic [31:0]        last_out_time_reg, last_out_time_next;

    byte_win_t   win_a, win_r, win_shift;
    logic        full, produces, start_hit, started_a, hdr_match, jump_hit, seq_ge;
    logic [15:0] in_seq, out_seq, jump;
    logic [31:0] in_ts, in_ssrc, out_ts, ssrc_new;

    assign full      = (fill_reg == FullFill);
    assign produces  = (item_opcode == OpData) && (item_seg_end || full);
    assign item_take = item_valid && (!produces || drain_free);

    always_comb begin
        win_a = win_reg;
        for (int i = 0; i < WinLen; i++) begin
            if (fill_reg == FillW'(i)) begin
                win_a[i] = item_byte;
            end
        end

        // Stream opens on a segment whose 5th/6th bytes look like RTP
        start_hit = !started_reg && head_reg && (fill_reg == StartFill) &&
                    (win_a[4] == HdrVersion) && pt_ok(win_a[5]);
        started_a = started_reg || start_hit;

        hdr_match = started_a && full && (win_a[0] == HdrDollar) &&
                    (win_a[1] == HdrChan0) && (win_a[4] == HdrVersion) &&
                    pt_ok(win_a[5]);

        in_seq  = {win_a[6], win_a[7]};
        in_ts   = {win_a[8], win_a[9], win_a[10], win_a[11]};
        in_ssrc = {win_a[12], win_a[13], win_a[14], win_a[15]};

        seq_ge   = (in_seq >= last_in_seq_reg);
        jump     = seq_ge ? (in_seq - last_in_seq_reg) : (last_in_seq_reg - in_seq);
        jump_hit = armed_reg && (jump > jump_threshold);

        // On a jump the new offset lands exactly on the last outgoing values
        out_seq  = jump_hit ? last_out_seq_reg  : (in_seq + seq_off_reg);
        out_ts   = jump_hit ? last_out_time_reg : (in_ts + time_off_reg);
        ssrc_new = (jump_hit && (ssrc_ovr_reg == 32'd0)) ? last_in_ssrc_reg : ssrc_ovr_reg;

        win_r = win_a;
        if (hdr_match) begin
            win_r[6]  = out_seq[15:8];
            win_r[7]  = out_seq[7:0];
            win_r[8]  = out_ts[31:24];
            win_r[9]  = out_ts[23:16];
            win_r[10] = out_ts[15:8];
            win_r[11] = out_ts[7:0];
            if (ssrc_new != 32'd0) begin
                win_r[12] = ssrc_new[31:24];
                win_r[13] = ssrc_new[23:16];
                win_r[14] = ssrc_new[15:8];
                win_r[15] = ssrc_new[7:0];
            end
        end

        for (int i = 0; i < WinLen - 1; i++) begin
            win_shift[i] = win_r[i+1];
        end
        win_shift[WinLen-1] = 8'h00;
    end

    always_comb begin
        win_next           = win_reg;
        fill_next          = fill_reg;
        head_next          = head_reg;
        started_next       = started_reg;
        armed_next         = armed_reg;
        seq_off_next       = seq_off_reg;
        time_off_next      = time_off_reg;
        ssrc_ovr_next      = ssrc_ovr_reg;
        last_in_seq_next   = last_in_seq_reg;
        last_in_ssrc_next  = last_in_ssrc_reg;
        last_out_seq_next  = last_out_seq_reg;
        last_out_time_next = last_out_time_reg;

        if (item_take) begin
            if (item_opcode == OpArm) begin
                armed_next = 1'b1;
            end else begin
                started_next = started_a;
                if (hdr_match) begin
                    last_in_seq_next   = in_seq;
                    last_in_ssrc_next  = in_ssrc;
                    last_out_seq_next  = out_seq;
                    last_out_time_next = out_ts;
                    if (jump_hit) begin
                        seq_off_next  = last_out_seq_reg - in_seq;
                        time_off_next = last_out_time_reg - in_ts;
                        ssrc_ovr_next = ssrc_new;
                        armed_next    = 1'b0;
                    end
                end
                if (item_seg_end) begin
                    fill_next = '0;
                    head_next = 1'b1;
                end else if (full) begin
                    win_next  = win_shift;
                    head_next = 1'b0;
                end else begin
                    win_next  = win_a;
                    fill_next = fill_reg + FillW'(1);
                end
            end
        end
    end

    always_comb begin
        load.load      = item_take && produces;
        load.seg_flush = item_seg_end;
        load.count     = item_seg_end ? (CountW'(fill_reg) + CountW'(1)) : CountW'(1);
        load_bytes     = win_r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg          <= '0;
            head_reg          <= 1'b1;
            started_reg       <= 1'b0;
            armed_reg         <= 1'b0;
            seq_off_reg       <= '0;
            time_off_reg      <= '0;
            ssrc_ovr_reg      <= '0;
            last_in_seq_reg   <= '0;
            last_in_ssrc_reg  <= '0;
            last_out_seq_reg  <= '0;
            last_out_time_reg <= '0;
        end else begin
            fill_reg          <= fill_next;
            head_reg          <= head_next;
            started_reg       <= started_next;
            armed_reg         <= armed_next;
            seq_off_reg       <= seq_off_next;
            time_off_reg      <= time_off_next;
            ssrc_ovr_reg      <= ssrc_ovr_next;
            last_in_seq_reg   <= last_in_seq_next;
            last_in_ssrc_reg  <= last_in_ssrc_next;
            last_out_seq_reg  <= last_out_seq_next;
            last_out_time_reg <= last_out_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    `RTP_IHR_ASSERT_NOW(a_load_needs_data, aclk, aresetn, load.load, item_take && (item_opcode == OpData))
    `RTP_IHR_ASSERT_NOW(a_single_when_no_flush, aclk, aresetn, load.load && !load.seg_flush, load.count == CountW'(1))
    `RTP_IHR_ASSERT_NEXT(a_flush_empties, aclk, aresetn, item_take && (item_opcode == OpData) && item_seg_end, fill_reg == '0)

endmodule

`default_nettype wire

// ===== src/rtp_ihr_drain.sv =====
// ----------------------------------------------------------------------------
// RTP header rewriter result buffer
// Holds up to one window of results and shifts them out one per handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtp_interleaved_header_rewriter_assert.svh"

module rtp_ihr_drain
    import rtp_ihr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire drain_load_t load,
    input  wire byte_win_t   load_bytes,
    output logic             drain_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_out_segment_end,
    output logic             m_run_last
);

    byte_win_t          bytes_reg, bytes_next;
    logic [CountW-1:0]  count_reg, count_next;
    logic               flush_reg, flush_next;
    logic               pop;

    assign m_valid           = (count_reg != '0);
    assign pop               = m_valid && m_ready;
    assign drain_free        = (count_reg == '0) || ((count_reg == CountW'(1)) && m_ready);
    assign m_out_byte        = bytes_reg[0];
    assign m_run_last        = (count_reg == CountW'(1));
    assign m_out_segment_end = (count_reg == CountW'(1)) && flush_reg;

    always_comb begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        flush_next = flush_reg;
        if (load.load) begin
            bytes_next = load_bytes;
            count_next = load.count;
            flush_next = load.seg_flush;
        end else if (pop) begin
            for (int i = 0; i < WinLen - 1; i++) begin
                bytes_next[i] = bytes_reg[i+1];
            end
            bytes_next[WinLen-1] = 8'h00;
            count_next = count_reg - CountW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flush_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

    `RTP_IHR_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CountW'(WinLen))
    `RTP_IHR_ASSERT_NOW(a_load_only_when_free, aclk, aresetn, load.load, drain_free)
    `RTP_IHR_ASSERT_NEXT(a_pop_counts_down, aclk, aresetn, pop && !load.load, count_reg == ($past(count_reg) - CountW'(1)))

endmodule

`default_nettype wire

// ===== src/rtp_interleaved_header_rewriter.sv =====
// ----------------------------------------------------------------------------
// RTP interleaved header rewriter
// Rewrites sequence, timestamp and SSRC of RTSP-interleaved RTP headers.
// ----------------------------------------------------------------------------
// Takes the bytes of received TCP segments, one byte or one arm-switch event per
// request, and gives out the same bytes with RTP headers renumbered so that the
// outgoing sequence and timestamp continue across a connection change. Output
// lags the input by the 16-byte window: nothing comes out while the window fills,
// then one byte per input byte, and a byte flagged as segment end flushes the
// whole window (1 to 16 results, one per output handshake). In steady state one
// byte is accepted per clock while the output is ready; the header compare, the
// jump test and the 32-bit offset adds are combinational between the input
// register and the result buffer, so the block runs one request per cycle while
// the output keeps up. A segment-end flush or a stalled output can hold the
// input: a result-giving request waits until the buffer's last result is taken.
// The jump threshold is a configuration write with reset value 100; write it
// only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_interleaved_header_rewriter
    import rtp_ihr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: jump threshold
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,

    // Input requests
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_segment_end,

    // Results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_out_segment_end,
    output logic             m_run_last
);

    logic [15:0] thresh_reg, thresh_next;

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic        in_seg_reg;
    logic        s_fire;

    logic        item_take;
    logic        drain_free;
    drain_load_t load;
    byte_win_t   load_bytes;

    // Always ready; the user must write thresh only between requests; unchecked.
    assign cfg_ready   = 1'b1;
    assign thresh_next = (cfg_valid && cfg_ready) ? cfg_data : thresh_reg;

    // Refill the input register as soon as the core takes the held request
    assign s_ready       = !in_valid_reg || item_take;
    assign s_fire        = s_valid && s_ready;
    assign in_valid_next = s_fire ? 1'b1 : (item_take ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= JumpThreshReset;
            in_valid_reg <= 1'b0;
        end else begin
            thresh_reg   <= thresh_next;
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the payload until the next request lands
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg   <= s_opcode;
            in_byte_reg <= s_data_byte;
            in_seg_reg  <= s_segment_end;
        end
    end

    rtp_ihr_window u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .jump_threshold (thresh_reg),
        .item_valid     (in_valid_reg),
        .item_opcode    (in_op_reg),
        .item_byte      (in_byte_reg),
        .item_seg_end   (in_seg_reg),
        .drain_free     (drain_free),
        .item_take      (item_take),
        .load           (load),
        .load_bytes     (load_bytes)
    );

    rtp_ihr_drain u_drain (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (load),
        .load_bytes        (load_bytes),
        .drain_free        (drain_free),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_out_segment_end (m_out_segment_end),
        .m_run_last        (m_run_last)
    );

endmodule

`default_nettype wire
